// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, on aclk/aresetn or on a given clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define AHS_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// house form: block clock and reset
`define AHS_ASSERT(label, prop, msg) \
    `AHS_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/ahs_pkg.sv =====
// ----------------------------------------------------------------------------
// ahs_pkg
// Constants, types, sine table and sequencer codes of the additive synthesizer.
// ----------------------------------------------------------------------------
package ahs_pkg;

    localparam int MAX_HARMONICS   = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER_LEN     = 1 << QUARTER_BITS;

    localparam int SLOT_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int CNT_W  = $clog2(MAX_HARMONICS + 1);
    // |sine * weight| <= 2^30, summed over all slots
    localparam int ACC_W   = 32 + SLOT_W;
    localparam int SCALE_W = ACC_W + 17;

    // request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARMONICS = 2'd1;

    localparam logic [15:0] AMPLITUDE_RESET = 16'h8000;

    // one harmonic slot as stored
    typedef struct packed {
        logic [31:0] step;
        logic [31:0] start;
        logic [15:0] weight;
    } slot_t;

    // ---------------- microcode ----------------
    localparam int STEP_W    = 3;
    localparam int NUM_STEPS = 5;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_SCALE = 3'd2;
    localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_OUT   = 3'd4;

    localparam logic [2:0] COND_NEVER     = 3'd0;
    localparam logic [2:0] COND_ALWAYS    = 3'd1;
    localparam logic [2:0] COND_NO_START  = 3'd2;
    localparam logic [2:0] COND_LOOP_BUSY = 3'd3;
    localparam logic [2:0] COND_OUT_FULL  = 3'd4;

    typedef struct packed {
        logic              in_ready;
        logic              issue_en;
        logic              scale_en;
        logic              out_load;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic loop_busy;
        logic out_full;
    } status_t;

    // ---------------- sine table ----------------
    localparam logic [63:0] SINE_HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [0:6] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef logic [15:0] sine_tab_t [0:QUARTER_LEN];

    // Q2.30 Taylor series up to the x^15 term, truncated terms, rounded half up to Q1.15
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (SINE_HALF_PI_Q30 * 64'(k)) >> QUARTER_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = ($unsigned(sum) + 64'd16384) >> 15;
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            tab[k] = r[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== rtl/ahs_seq.sv =====
// ----------------------------------------------------------------------------
// ahs_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ahs_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  ahs_pkg::status_t status,
    output ahs_pkg::ctrl_t   ctrl
);

    // in_ready, issue_en, scale_en, out_load, cond, target
    localparam ahs_pkg::ctrl_t PROGRAM [0:ahs_pkg::NUM_STEPS-1] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, ahs_pkg::COND_NO_START,  ahs_pkg::STEP_IDLE},
        '{1'b0, 1'b1, 1'b0, 1'b0, ahs_pkg::COND_LOOP_BUSY, ahs_pkg::STEP_LOOP},
        '{1'b0, 1'b0, 1'b1, 1'b0, ahs_pkg::COND_NEVER,     ahs_pkg::STEP_IDLE},
        '{1'b0, 1'b0, 1'b0, 1'b0, ahs_pkg::COND_OUT_FULL,  ahs_pkg::STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b1, ahs_pkg::COND_ALWAYS,    ahs_pkg::STEP_IDLE}
    };

    logic [ahs_pkg::STEP_W-1:0] pc_reg;
    logic [ahs_pkg::STEP_W-1:0] pc_next;
    logic                       take;

    always_comb begin
        if (int'(pc_reg) < ahs_pkg::NUM_STEPS) begin
            ctrl = PROGRAM[pc_reg];
        end else begin
            ctrl = PROGRAM[0];
        end
    end

    always_comb begin
        case (ctrl.cond)
            ahs_pkg::COND_NEVER:     take = 1'b0;
            ahs_pkg::COND_ALWAYS:    take = 1'b1;
            ahs_pkg::COND_NO_START:  take = !status.start;
            ahs_pkg::COND_LOOP_BUSY: take = status.loop_busy;
            ahs_pkg::COND_OUT_FULL:  take = status.out_full;
            default:                 take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ahs_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/additive_harmonic_synth_top.sv =====
// ----------------------------------------------------------------------------
// additive_harmonic_synth_top
// One additive-synthesis sample per request from up to 16 harmonic slots.
// ----------------------------------------------------------------------------
// A load item writes one harmonic slot. A sample item walks the first
// harmonics_in_use slots (capped at 16) through a four-stage pipeline -
// slot RAM read, phase multiply, quarter-wave sine lookup, sine x weight
// accumulate - one slot per cycle, then scales by amplitude, rounds and
// saturates. The slot walk runs through the single multiply-accumulate path.
// The result register frees the input side once the result is loaded, but
// the next item is taken only after the current result has been loaded, and
// a finished sample waits while the previous result is still held.
`include "assert_macros.svh"

module additive_harmonic_synth_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ahs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [15:0]                         cfg_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [3:0]                          s_harmonic_slot,
    input  logic [31:0]                         s_phase_step,
    input  logic [31:0]                         s_start_phase,
    input  logic signed [15:0]                  s_weight,
    input  logic [31:0]                         s_sample_index,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_sample_value
);

    localparam int TB      = ahs_pkg::SINE_TABLE_BITS;
    localparam int QB      = ahs_pkg::QUARTER_BITS;
    localparam int SCALE_W = ahs_pkg::SCALE_W;
    localparam int ACC_W   = ahs_pkg::ACC_W;
    localparam int CNT_W   = ahs_pkg::CNT_W;
    localparam int SLOT_W  = ahs_pkg::SLOT_W;

    localparam logic signed [SCALE_W-1:0] ROUND_BIAS = SCALE_W'(1 << 18);
    localparam logic signed [SCALE_W-1:0] SAT_MAX =
        {{(SCALE_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SCALE_W-1:0] SAT_MIN =
        {{(SCALE_W-31){1'b1}}, {31{1'b0}}};

    ahs_pkg::ctrl_t   ctrl;
    ahs_pkg::status_t status;

    // configuration
    logic [15:0]      amp_reg;
    logic [4:0]       harm_reg;

    // sample setup
    logic [31:0]      n_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             issue;
    logic             start;
    logic             load;

    // slot memory and pipeline
    ahs_pkg::slot_t   slot_mem [0:ahs_pkg::MAX_HARMONICS-1];
    ahs_pkg::slot_t   rd_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [31:0]      phase_reg;
    logic [15:0]      w2_reg;
    logic [15:0]      w3_reg;
    logic signed [16:0] sine_reg;
    logic signed [16:0] sine_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SCALE_W-1:0] scale_reg;

    // sine lookup
    logic [TB-1:0]    top_bits;
    logic [1:0]       quad;
    logic [QB-1:0]    qi;
    logic [QB:0]      tab_idx;
    logic [15:0]      mag;

    // output
    logic signed [SCALE_W-1:0] rnd_sum;
    logic signed [SCALE_W-1:0] rnd_shift;
    logic signed [31:0]        sat_value;
    logic                      m_valid_reg;
    logic signed [31:0]        m_value_reg;

    ahs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = ctrl.in_ready;
    assign start     = s_valid && s_ready && (s_req_type == ahs_pkg::REQ_SAMPLE);
    assign load      = s_valid && s_ready && (s_req_type == ahs_pkg::REQ_LOAD);
    assign issue     = ctrl.issue_en && (issue_cnt_reg < count_reg);

    assign status.start     = start;
    assign status.loop_busy = issue || v1_reg || v2_reg || v3_reg;
    assign status.out_full  = m_valid_reg && !m_ready;

    assign count_next = (int'(harm_reg) > ahs_pkg::MAX_HARMONICS)
                      ? CNT_W'(ahs_pkg::MAX_HARMONICS) : CNT_W'(harm_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_reg  <= ahs_pkg::AMPLITUDE_RESET;
            harm_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ahs_pkg::REG_AMPLITUDE: amp_reg  <= cfg_data;
                ahs_pkg::REG_HARMONICS: harm_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // slot RAM: written by load transfers, read one slot per cycle in the walk
    always_ff @(posedge aclk) begin
        if (load && (int'(s_harmonic_slot) < ahs_pkg::MAX_HARMONICS)) begin
            slot_mem[SLOT_W'(s_harmonic_slot)] <= '{s_phase_step, s_start_phase, s_weight};
        end
        if (issue) begin
            rd_reg <= slot_mem[issue_cnt_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            if (start) begin
                issue_cnt_reg <= '0;
                count_reg     <= count_next;
            end else if (issue) begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb begin
        top_bits  = phase_reg[31 -: TB];
        quad      = top_bits[TB-1 -: 2];
        qi        = top_bits[QB-1:0];
        tab_idx   = quad[0] ? ((QB+1)'(ahs_pkg::QUARTER_LEN) - {1'b0, qi}) : {1'b0, qi};
        mag       = ahs_pkg::SINE_TAB[tab_idx];
        sine_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg <= s_sample_index;
        end
        if (v1_reg) begin
            phase_reg <= rd_reg.start + n_reg * rd_reg.step;
            w2_reg    <= rd_reg.weight;
        end
        if (v2_reg) begin
            sine_reg <= sine_next;
            w3_reg   <= w2_reg;
        end
        if (start) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + ACC_W'(sine_reg * $signed(w3_reg));
        end
        if (ctrl.scale_en) begin
            scale_reg <= SCALE_W'(acc_reg) * SCALE_W'($signed({1'b0, amp_reg}));
        end
    end

    // round half up to Q8.23, floor shift, saturate
    always_comb begin
        rnd_sum   = scale_reg + ROUND_BIAS;
        rnd_shift = rnd_sum >>> 19;
        if (rnd_shift > SAT_MAX) begin
            sat_value = 32'sh7fffffff;
        end else if (rnd_shift < SAT_MIN) begin
            sat_value = 32'sh80000000;
        end else begin
            sat_value = rnd_shift[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_value_reg <= sat_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_value_reg;

    // walk pipeline only carries slots while the loop step runs
    `AHS_ASSERT(a_pipe_in_loop, (v1_reg || v2_reg || v3_reg) |-> ctrl.issue_en, "slot pipeline live outside loop step")
    // never accept a request while slots are still in flight
    `AHS_ASSERT(a_ready_idle, s_ready |-> !(v1_reg || v2_reg || v3_reg), "request ready with slots in flight")
    // walk never passes the slot count
    `AHS_ASSERT(a_issue_bound, issue_cnt_reg <= count_reg, "slot walk ran past count")
    // a held result is never overwritten
    `AHS_ASSERT(a_no_overwrite, ctrl.out_load |-> (!m_valid_reg || m_ready), "result overwritten before transfer")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for additive_harmonic_synth_top. Harmonic slots are
// loaded and samples requested over the request port with random sender gaps
// and result back-pressure. Every sample is checked against a bit-accurate
// predictor kept here. Amplitude and harmonic count are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic               req_type;
        logic [3:0]         slot;
        logic [31:0]        step;
        logic [31:0]        start;
        logic signed [15:0] weight;
        logic [31:0]        index;
    } synth_req_t;

    localparam int CLK_PERIOD      = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES  = 600000;
    localparam int MAX_H           = ahs_pkg::MAX_HARMONICS;
    localparam int TAB_BITS        = ahs_pkg::SINE_TABLE_BITS;
    localparam int Q_BITS          = ahs_pkg::QUARTER_BITS;
    localparam int Q_LEN           = ahs_pkg::QUARTER_LEN;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // indexes with no register behind them; writes must be ignored
    localparam logic [ahs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [ahs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                         aclk;
    logic                         aresetn         = 1'b0;
    logic                         cfg_valid       = 1'b0;
    logic                         cfg_ready;
    logic [ahs_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
    logic [15:0]                  cfg_data        = '0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic                         s_req_type      = 1'b0;
    logic [3:0]                   s_harmonic_slot = '0;
    logic [31:0]                  s_phase_step    = '0;
    logic [31:0]                  s_start_phase   = '0;
    logic signed [15:0]           s_weight        = '0;
    logic [31:0]                  s_sample_index  = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic signed [31:0]           m_sample_value;

    additive_harmonic_synth_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_harmonic_slot (s_harmonic_slot),
        .s_phase_step    (s_phase_step),
        .s_start_phase   (s_start_phase),
        .s_weight        (s_weight),
        .s_sample_index  (s_sample_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_value  (m_sample_value)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // shadow copy of the block state
    logic [15:0]        sine_lut      [0:Q_LEN];
    logic [31:0]        shadow_step   [MAX_H];
    logic [31:0]        shadow_start  [MAX_H];
    logic signed [15:0] shadow_weight [MAX_H];
    logic [15:0]        shadow_amp;
    logic [4:0]         shadow_count;

    synth_req_t         pending_reqs[$];
    logic signed [31:0] expected_samples[$];

    int errors    = 0;
    bit tx_calm   = 1'b0;
    bit rx_calm   = 1'b0;
    int hold_req  = 0;
    int hold_done = 0;
    int hold_left = 0;

    // Q2.30 Taylor series of sin(pi/2 * k/Q), truncated terms, rounded to Q1.15
    function automatic logic [15:0] quarter_sine(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        x    = ((64'd3373259426 / 64'd2) * 64'(k)) >> Q_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (64'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

    function automatic int sine_at(logic [31:0] phase);
        logic [TAB_BITS-1:0] top;
        logic [1:0]          quad;
        logic [Q_BITS-1:0]   pos;
        int                  mag;
        top  = phase[31 -: TAB_BITS];
        quad = top[TAB_BITS-1 -: 2];
        pos  = top[Q_BITS-1:0];
        mag  = quad[0] ? int'(sine_lut[Q_LEN - int'(pos)]) : int'(sine_lut[pos]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] synth_sample(logic [31:0] n);
        longint      acc;
        longint      scaled;
        int          count;
        logic [31:0] phase;
        acc   = 0;
        count = (int'(shadow_count) > MAX_H) ? MAX_H : int'(shadow_count);
        for (int i = 0; i < count; i++) begin
            phase = shadow_start[i] + n * shadow_step[i];
            acc   = acc + longint'(sine_at(phase)) * longint'(shadow_weight[i]);
        end
        // round Q.42 to Q8.23; arithmetic shift gives the floor
        scaled = (acc * longint'(shadow_amp) + 64'sd262144) >>> 19;
        if (scaled > SAT_HI) begin
            scaled = SAT_HI;
        end
        if (scaled < SAT_LO) begin
            scaled = SAT_LO;
        end
        return scaled[31:0];
    endfunction

    function automatic void apply_req(synth_req_t r);
        if (r.req_type == ahs_pkg::REQ_LOAD) begin
            if (int'(r.slot) < MAX_H) begin
                shadow_step[r.slot]   = r.step;
                shadow_start[r.slot]  = r.start;
                shadow_weight[r.slot] = r.weight;
            end
        end else begin
            expected_samples.push_back(synth_sample(r.index));
        end
    endfunction

    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // ---------------- request driver ----------------
    synth_req_t cur_req;
    int         tx_gap = 0;

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_req(cur_req);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    s_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    cur_req          = pending_reqs.pop_front();
                    s_valid         <= 1'b1;
                    s_req_type      <= cur_req.req_type;
                    s_harmonic_slot <= cur_req.slot;
                    s_phase_step    <= cur_req.step;
                    s_start_phase   <= cur_req.start;
                    s_weight        <= cur_req.weight;
                    s_sample_index  <= cur_req.index;
                    tx_gap          <= draw_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, requested by the stimulus
    always @(posedge aclk) begin : hold_off
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_done) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= hold_req;
        end
    end

    // ---------------- result monitor ----------------
    int rx_wait = 0;

    always @(posedge aclk) begin : monitor
        int                 idle_n;
        logic signed [31:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            idle_n = rx_wait;
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected sample transfer: got %0d", m_sample_value);
                    end
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample_value !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("sample_value mismatch: expected %0d, got %0d",
                                     want, m_sample_value);
                        end
                    end
                end
                idle_n = draw_gap(rx_calm);
            end
            if (idle_n > 0) begin
                m_ready <= 1'b0;
                rx_wait <= idle_n - 1;
            end else begin
                m_ready <= (hold_left == 0);
                rx_wait <= 0;
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_index();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 255);
        end
        return rand_word();
    endfunction

    task automatic push_load(logic [3:0] slot, logic [31:0] step, logic [31:0] start,
                             logic signed [15:0] w);
        synth_req_t r;
        r.req_type = ahs_pkg::REQ_LOAD;
        r.slot     = slot;
        r.step     = step;
        r.start    = start;
        r.weight   = w;
        r.index    = $urandom();
        pending_reqs.push_back(r);
    endtask

    task automatic push_sample(logic [31:0] n);
        synth_req_t r;
        r.req_type = ahs_pkg::REQ_SAMPLE;
        r.slot     = 4'($urandom());
        r.step     = $urandom();
        r.start    = $urandom();
        r.weight   = 16'($urandom());
        r.index    = n;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int n_items, int sample_pct);
        repeat (n_items) begin
            if ($urandom_range(0, 99) < sample_pct) begin
                push_sample(rand_index());
            end else begin
                push_load(4'($urandom_range(0, 15)), rand_word(), rand_word(), rand_weight());
            end
        end
    endtask

    // all requests transferred and all samples back, then let the pipe settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [ahs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ahs_pkg::REG_AMPLITUDE: shadow_amp   = data;
            ahs_pkg::REG_HARMONICS: shadow_count = data[4:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic random_config();
        logic [15:0] amp;
        logic [4:0]  cnt;
        case ($urandom_range(0, 3))
            0:       amp = 16'h0000;
            1:       amp = 16'hFFFF;
            2:       amp = ahs_pkg::AMPLITUDE_RESET;
            default: amp = 16'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       cnt = 5'd0;
            1:       cnt = 5'd1;
            2:       cnt = 5'd16;
            3:       cnt = 5'($urandom_range(17, 31));
            default: cnt = 5'($urandom_range(2, 15));
        endcase
        write_reg(ahs_pkg::REG_AMPLITUDE, amp);
        write_reg(ahs_pkg::REG_HARMONICS, {11'($urandom()), cnt});
        if ($urandom_range(0, 1) == 1) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom()));
        end
    endtask

    initial begin : stimulus
        for (int k = 0; k <= Q_LEN; k++) begin
            sine_lut[k] = quarter_sine(k);
        end
        shadow_amp   = ahs_pkg::AMPLITUDE_RESET;
        shadow_count = '0;
        for (int i = 0; i < MAX_H; i++) begin
            shadow_step[i]   = '0;
            shadow_start[i]  = '0;
            shadow_weight[i] = '0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // count is zero after reset: samples sum nothing
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        // fill every slot before any count can reach it
        push_load(4'd0, 32'h4000_0000, 32'h0000_0000, 16'sh7FFF);
        push_load(4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh8000);
        push_load(4'd2, 32'h0000_0000, 32'h8000_0000, 16'sh0000);
        for (int s = 3; s < MAX_H; s++) begin
            push_load(4'(s), rand_word(), rand_word(), rand_weight());
        end
        wait_idle();

        // one harmonic, quarter-cycle steps: one sample per quadrant
        write_reg(ahs_pkg::REG_HARMONICS, 16'd1);
        write_reg(ahs_pkg::REG_AMPLITUDE, 16'hFFFF);
        for (int n = 0; n < 4; n++) begin
            push_sample(32'(n));
        end
        wait_idle();

        write_reg(ahs_pkg::REG_AMPLITUDE, 16'h0000);
        write_reg(ahs_pkg::REG_HARMONICS, 16'd16);
        push_sample($urandom());
        wait_idle();

        // count above capacity, writes to unused indexes
        write_reg(ahs_pkg::REG_AMPLITUDE, 16'hFFFF);
        write_reg(ahs_pkg::REG_HARMONICS, 16'hFFFF);
        write_reg(REG_SPARE_A, 16'($urandom()));
        write_reg(REG_SPARE_B, 16'($urandom()));
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            random_config();
            tx_calm = (ph == 1 || ph == 3);
            rx_calm = (ph == 2);
            if (ph == 3) begin
                // receiver stalls while the sender keeps offering samples
                hold_req++;
                push_random(300, 90);
            end else begin
                push_random(300, 60);
            end
        end

        wait_idle();
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ahs_pkg.sv
rtl/ahs_seq.sv
rtl/additive_harmonic_synth_top.sv
tb/tb_top.sv
